// ----- src/vlv_pkg.sv -----
package vlv_pkg;

  // widths
  localparam int COUNT_WIDTH = 24;
  localparam int STOP_W      = 24;
  localparam int SETTLE_W    = 16;
  localparam int SPEED_W     = 8;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CMP_W       = (COUNT_WIDTH > STOP_W) ? COUNT_WIDTH : STOP_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SETTING = 2'd2;

  // register reset values
  localparam logic [STOP_W-1:0]   TIMEOUT_LIMIT_RST = 24'd100000;
  localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST  = 16'd3000;
  localparam logic [SPEED_W-1:0]  SPEED_SETTING_RST = 8'd255;

  // action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_OPEN  = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;

  // decoded position codes
  localparam logic [1:0] POS_OPENED = 2'd0;
  localparam logic [1:0] POS_CLOSED = 2'd1;
  localparam logic [1:0] POS_UNDEF  = 2'd2;

  // motor drive codes
  localparam logic [1:0] DRV_STOP  = 2'd0;
  localparam logic [1:0] DRV_OPEN  = 2'd1;
  localparam logic [1:0] DRV_CLOSE = 2'd2;

  // target position (one bit)
  localparam logic TGT_OPENED = 1'b0;
  localparam logic TGT_CLOSED = 1'b1;

  // control phase codes
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_MOVING   = 2'd1;
  localparam logic [1:0] PH_SETTLING = 2'd2;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef struct packed {
    logic [STOP_W-1:0]   timeout_limit;
    logic [SETTLE_W-1:0] settle_ticks;
    logic [SPEED_W-1:0]  speed_setting;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         motor_drive;
    logic [SPEED_W-1:0] drive_speed;
    logic [1:0]         position;
    logic               busy_res;
    logic               done_res;
    logic               success;
  } result_t;

endpackage

// ----- src/vlv_cfg_regs.sv -----
module vlv_cfg_regs
  import vlv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  // register file, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_limit <= TIMEOUT_LIMIT_RST;
      cfg_r.settle_ticks  <= SETTLE_TICKS_RST;
      cfg_r.speed_setting <= SPEED_SETTING_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT_LIMIT: cfg_r.timeout_limit <= cfg_wdata[STOP_W-1:0];
        CFG_SETTLE_TICKS:  cfg_r.settle_ticks  <= cfg_wdata[SETTLE_W-1:0];
        CFG_SPEED_SETTING: cfg_r.speed_setting <= cfg_wdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/vlv_ctrl.sv -----
module vlv_ctrl
  import vlv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [1:0] action,
  input  logic       open_lvl,
  input  logic       closed_lvl,
  input  cfg_t       cfg,
  output result_t    res
);

  logic [1:0]             phase_r, phase_nxt;
  logic                   target_r, target_nxt;
  logic [COUNT_WIDTH-1:0] iter_r, iter_nxt;
  logic [SETTLE_W-1:0]    settle_r, settle_nxt;

  logic [1:0]             pos;
  logic                   at_target;
  logic                   cmd;
  logic                   cmd_tgt;
  logic [COUNT_WIDTH-1:0] iter_inc;
  logic                   timeout;
  logic [1:0]             run_drive;

  // switch decode, both levels equal means undefined
  always_comb begin
    if (open_lvl == closed_lvl) begin
      pos = POS_UNDEF;
    end else if (!open_lvl) begin
      pos = POS_OPENED;
    end else begin
      pos = POS_CLOSED;
    end
  end

  assign cmd       = action inside {ACT_OPEN, ACT_CLOSE};
  assign cmd_tgt   = (action == ACT_CLOSE) ? TGT_CLOSED : TGT_OPENED;
  assign at_target = (pos == {1'b0, target_r});
  assign run_drive = (target_r == TGT_CLOSED) ? DRV_CLOSE : DRV_OPEN;

  // saturating iteration count and timeout compare
  assign iter_inc = (iter_r != COUNT_MAX) ? iter_r + 1'b1 : iter_r;
  assign timeout  = (CMP_W'(iter_inc) >= CMP_W'(cfg.timeout_limit));

  // next state and result for one item
  always_comb begin
    phase_nxt       = phase_r;
    target_nxt      = target_r;
    iter_nxt        = iter_r;
    settle_nxt      = settle_r;
    res.motor_drive = DRV_STOP;
    res.drive_speed = cfg.speed_setting;
    res.position    = pos;
    res.busy_res    = 1'b0;
    res.done_res    = 1'b0;
    res.success     = 1'b0;
    case (phase_r)
      PH_MOVING: begin
        if (at_target) begin
          phase_nxt       = PH_SETTLING;
          settle_nxt      = cfg.settle_ticks;
          res.busy_res    = 1'b1;
          res.motor_drive = run_drive;
        end else begin
          iter_nxt = iter_inc;
          if (timeout) begin
            phase_nxt    = PH_IDLE;
            res.done_res = 1'b1;
          end else begin
            res.busy_res    = 1'b1;
            res.motor_drive = run_drive;
          end
        end
      end
      PH_SETTLING: begin
        if (settle_r != '0) begin
          settle_nxt      = settle_r - 1'b1;
          res.busy_res    = 1'b1;
          res.motor_drive = run_drive;
        end else begin
          iter_nxt = iter_inc;
          if (timeout) begin
            phase_nxt    = PH_IDLE;
            res.done_res = 1'b1;
          end else if (at_target) begin
            phase_nxt    = PH_IDLE;
            res.done_res = 1'b1;
            res.success  = 1'b1;
          end else begin
            phase_nxt       = PH_MOVING;
            res.busy_res    = 1'b1;
            res.motor_drive = run_drive;
          end
        end
      end
      default: begin
        // idle, and the unused code behaves as idle
        phase_nxt = PH_IDLE;
        if (cmd) begin
          target_nxt = cmd_tgt;
          if (pos == {1'b0, cmd_tgt}) begin
            res.done_res = 1'b1;
            res.success  = 1'b1;
          end else begin
            phase_nxt       = PH_MOVING;
            iter_nxt        = '0;
            settle_nxt      = '0;
            res.busy_res    = 1'b1;
            res.motor_drive = (cmd_tgt == TGT_CLOSED) ? DRV_CLOSE : DRV_OPEN;
          end
        end
      end
    endcase
  end

  // state update once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      target_r <= TGT_OPENED;
      iter_r   <= '0;
      settle_r <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      target_r <= target_nxt;
      iter_r   <= iter_nxt;
      settle_r <= settle_nxt;
    end
  end

endmodule

// ----- src/valve_actuator_limit_switch_fsm.sv -----
// Valve actuator controller with two active-low limit switches. Each request
// carries an action (tick, open, close) and both switch levels, and produces
// exactly one result with the motor drive, speed, decoded position and the
// busy/done/success flags. The block takes one request per clock cycle while
// in_stall is low; a result passes through the input register and then the
// result register, and stays in the result register until it is taken. A
// stalled result holds the pipeline: the input register then fills and
// in_stall rises. Configuration registers (timeout limit, settle ticks, speed
// setting) are written through the cfg port; the user must do so only while
// no request is in flight, as the block itself does not enforce it.
module valve_actuator_limit_switch_fsm
  import vlv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_action,
  input  logic                  in_open_switch_level,
  input  logic                  in_closed_switch_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_motor_drive,
  output logic [SPEED_W-1:0]    out_drive_speed,
  output logic [1:0]            out_position,
  output logic                  out_busy_res,
  output logic                  out_done_res,
  output logic                  out_success
);

  cfg_t    cfg;
  result_t res;
  result_t res_r;

  logic       s1_valid_r, s1_valid_nxt;
  logic [1:0] s1_action_r;
  logic       s1_open_r;
  logic       s1_closed_r;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       s1_adv;
  logic       in_acc;

  vlv_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // handshake between the two register stages
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_free ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= in_action;
      s1_open_r   <= in_open_switch_level;
      s1_closed_r <= in_closed_switch_level;
    end
  end

  vlv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (s1_adv),
    .action     (s1_action_r),
    .open_lvl   (s1_open_r),
    .closed_lvl (s1_closed_r),
    .cfg        (cfg),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_motor_drive = res_r.motor_drive;
  assign out_drive_speed = res_r.drive_speed;
  assign out_position    = res_r.position;
  assign out_busy_res    = res_r.busy_res;
  assign out_done_res    = res_r.done_res;
  assign out_success     = res_r.success;

endmodule

// ----- src/vlv_checker.sv -----
module vlv_checker
  import vlv_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_motor_drive,
  input logic [1:0] out_position,
  input logic       out_busy_res,
  input logic       out_done_res,
  input logic       out_success
);

  // a running motor and a busy flag go together
  a_busy_drives: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_busy_res |-> out_motor_drive != DRV_STOP && !out_done_res)
    else $error("busy result without motor drive or with done");

  a_idle_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_motor_drive == DRV_STOP)
    else $error("motor driven while not busy");

  // success only reported on a finishing result
  a_success_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_success |-> out_done_res)
    else $error("success without done");

  a_pos_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_position == POS_OPENED || out_position == POS_CLOSED ||
                  out_position == POS_UNDEF)
    else $error("invalid position code");

  // a stalled result stays in place
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_motor_drive) &&
                               $stable(out_done_res))
    else $error("stalled result changed");

endmodule

bind valve_actuator_limit_switch_fsm vlv_checker u_vlv_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_motor_drive (out_motor_drive),
  .out_position    (out_position),
  .out_busy_res    (out_busy_res),
  .out_done_res    (out_done_res),
  .out_success     (out_success)
);
